/* hdl/lpre_pkg.sv */
// Shared types and constants for the length-prefixed record extractor.
// No dependencies; imported by every module of the block.
package lpre_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned HDR_W    = 16;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SKIP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_SKIP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUFFIX_SKIP = 2'd2;

   // Smallest legal record length: the first byte plus the two length bytes
   localparam logic [CNT_W-1:0] MIN_REC_LEN = 16'd3;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_PREFIX = 3'd1,
      PH_REC0   = 3'd2,
      PH_REC1   = 3'd3,
      PH_REC2   = 3'd4,
      PH_BODY   = 3'd5,
      PH_SUFFIX = 3'd6
   } phase_type;

   typedef struct packed {
      logic [HDR_W-1:0]  header_skip;
      logic [BYTE_W-1:0] prefix_skip;
      logic [BYTE_W-1:0] suffix_skip;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              record_end;
      logic              short_length;
   } result_type;

endpackage

/* hdl/lpre_deframe.sv */
// Deframing state machine: skip counters, length capture and record tracking.
// Depends on lpre_pkg for the phase enum, configuration and result structs.
module lpre_deframe import lpre_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_end,
   input  cfg_type           cfg,
   output logic              emit,
   output result_type        result
);

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  skip_count_ff, skip_count_in;
   logic [CNT_W-1:0]  record_left_ff, record_left_in;
   logic [BYTE_W-1:0] length_high_ff, length_high_in;
   logic              short_seen_ff, short_seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         skip_count_ff  <= '0;
         record_left_ff <= '0;
         length_high_ff <= '0;
         short_seen_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         skip_count_ff  <= skip_count_in;
         record_left_ff <= record_left_in;
         length_high_ff <= length_high_in;
         short_seen_ff  <= short_seen_in;
      end
   end

   always_comb begin
      phase_type         ph;
      logic [CNT_W-1:0]  cnt;
      logic [CNT_W-1:0]  rl;
      logic [CNT_W-1:0]  len;
      logic [BYTE_W-1:0] lh;
      logic              ss;
      logic              done;
      logic              rec_end;

      ph      = phase_ff;
      cnt     = skip_count_ff;
      rl      = record_left_ff;
      lh      = length_high_ff;
      ss      = short_seen_ff;
      len     = '0;
      done    = 1'b0;
      rec_end = 1'b0;
      emit    = 1'b0;

      // Header and suffix skips fall through to the prefix skip when exhausted
      case (ph)
         PH_SUFFIX: begin
            if (cnt < {8'd0, cfg.suffix_skip}) begin
               cnt  = cnt + 16'd1;
               done = 1'b1;
            end else begin
               ph  = PH_PREFIX;
               cnt = '0;
            end
         end
         PH_PREFIX, PH_REC0, PH_REC1, PH_REC2, PH_BODY: begin
         end
         default: begin
            ph = PH_HEADER;
            if (cnt < cfg.header_skip) begin
               cnt  = cnt + 16'd1;
               done = 1'b1;
            end else begin
               ph  = PH_PREFIX;
               cnt = '0;
            end
         end
      endcase

      if (!done && ph == PH_PREFIX) begin
         if (cnt < {8'd0, cfg.prefix_skip}) begin
            cnt  = cnt + 16'd1;
            done = 1'b1;
         end else begin
            ph = PH_REC0;
         end
      end

      if (!done) begin
         case (ph)
            PH_REC0: begin
               emit = 1'b1;
               ss   = 1'b0;
               ph   = PH_REC1;
            end
            PH_REC1: begin
               emit = 1'b1;
               lh   = in_byte;
               ph   = PH_REC2;
            end
            PH_REC2: begin
               emit = 1'b1;
               len  = {lh, in_byte};
               // force a short length to the minimum so the record ends here
               if (len < MIN_REC_LEN) begin
                  len = MIN_REC_LEN;
                  ss  = 1'b1;
               end
               rl = len - MIN_REC_LEN;
               if (rl == '0) begin
                  rec_end = 1'b1;
                  ph      = PH_SUFFIX;
                  cnt     = '0;
               end else begin
                  ph = PH_BODY;
               end
            end
            PH_BODY: begin
               emit = 1'b1;
               rl   = rl - 16'd1;
               if (rl == '0) begin
                  rec_end = 1'b1;
                  ph      = PH_SUFFIX;
                  cnt     = '0;
               end
            end
            default: begin
            end
         endcase
      end

      result.out_byte     = in_byte;
      result.record_end   = rec_end;
      result.short_length = ss;

      // Stream end: back to header skip after this beat
      if (in_end) begin
         ph  = PH_HEADER;
         cnt = '0;
         rl  = '0;
         lh  = '0;
         ss  = 1'b0;
      end

      if (advance) begin
         phase_in       = ph;
         skip_count_in  = cnt;
         record_left_in = rl;
         length_high_in = lh;
         short_seen_in  = ss;
      end else begin
         phase_in       = phase_ff;
         skip_count_in  = skip_count_ff;
         record_left_in = record_left_ff;
         length_high_in = length_high_ff;
         short_seen_in  = short_seen_ff;
      end
   end

endmodule

/* hdl/lpre_out_reg.sv */
// Result register of the record extractor: holds one result beat under stall.
// Depends on lpre_pkg for the result struct.
module lpre_out_reg import lpre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       free,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* hdl/length_prefixed_record_extractor_core.sv */
// Length-prefixed record extractor, top level.
// Depends on lpre_pkg, lpre_deframe and lpre_out_reg.
//
// Usage:
//   req_* carries the raw byte stream, one byte per beat; req_stream_end
//   marks the final byte of a stream and returns the block to header skip.
//   rsp_* carries the record bytes, with rsp_record_end on the last byte of
//   each record and rsp_short_length on a record whose length was forced to 3.
//   Both channels move a beat when valid is high and stall is low.
//   csr_* writes header_skip (index 0), prefix_skip (1) and suffix_skip (2);
//   write only while no beat is in flight.
// Timing:
//   A byte is registered in the input register on accept and decoded by the
//   phase logic; a byte that yields a result is loaded into the result
//   register once that register is free, and the result is then valid on
//   rsp_*. One byte per cycle is taken continuously while the receiver
//   keeps up; the input register and the result register each hold one beat.
// Reset and stall:
//   Reset clears the configuration and deframing registers to zero, the
//   phase to header skip and both pipeline stages to empty. A stalled result
//   holds; a byte that would produce a result waits in the input register,
//   and req_stall rises only while it waits.
module length_prefixed_record_extractor_core import lpre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_stream_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_record_end,
   output logic                 rsp_short_length,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type           cfg_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_end_ff;
   logic              s1_adv;
   logic              req_take;
   logic              emit;
   logic              out_free;
   result_type        result;
   result_type        rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_SKIP: cfg_ff.header_skip <= csr_wdata;
            CSR_PREFIX_SKIP: cfg_ff.prefix_skip <= csr_wdata[BYTE_W-1:0];
            CSR_SUFFIX_SKIP: cfg_ff.suffix_skip <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A beat that yields no result always advances; one that does needs a free slot
   assign s1_adv    = s1_valid_ff && (!emit || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_in_byte;
         s1_end_ff  <= req_stream_end;
      end
   end

   lpre_deframe u_deframe (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .in_byte (s1_byte_ff),
      .in_end  (s1_end_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   lpre_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv && emit),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_record_end   = rsp_data.record_end;
   assign rsp_short_length = rsp_data.short_length;

   // A forced length always closes the record on the same beat
   a_short_ends_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_short_length || rsp_record_end))
      else $error("short_length without record_end");

   // A waiting input beat keeps its byte until it advances
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_byte_ff)
                                   && $stable(s1_end_ff)))
      else $error("input stage lost a waiting beat");

   // An emitted beat shows up in the result register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && emit) |=> rsp_valid)
      else $error("emitted beat did not reach the result register");

   // Request stall only while an emitting input beat meets a stalled result
   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && emit && rsp_valid && rsp_stall))
      else $error("request stalled without a blocked beat");

endmodule
